// ----- hdl/ipf_pkg.sv -----
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared types, character codes and helper functions of the address text
// formatter.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int unsigned AddrW     = 64;
  localparam int unsigned KindW     = 2;
  localparam int unsigned BufLenW   = 6;
  localparam int unsigned ChrW      = 8;
  localparam int unsigned GroupW    = 16;
  localparam int unsigned NumGroups = 8;
  localparam int unsigned GrpIdxW   = 3;
  localparam int unsigned RunLenW   = 4;
  localparam int unsigned DigW      = 3;
  localparam int unsigned QuadW     = 32;

  typedef enum logic [KindW-1:0] {
    KIND_V4  = 2'd0,
    KIND_V6  = 2'd1,
    KIND_UNK = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PREFIX = 6'b000010,
    ST_HEX    = 6'b000100,
    ST_DEC    = 6'b001000,
    ST_QUERY  = 6'b010000,
    ST_NUL    = 6'b100000
  } state_e;

  localparam logic [ChrW-1:0] ChrNul   = 8'h00;
  localparam logic [ChrW-1:0] ChrDot   = 8'h2e;
  localparam logic [ChrW-1:0] ChrZero  = 8'h30;
  localparam logic [ChrW-1:0] ChrColon = 8'h3a;
  localparam logic [ChrW-1:0] ChrQuery = 8'h3f;
  localparam logic [ChrW-1:0] ChrLowF  = 8'h66;
  localparam logic [ChrW-1:0] ChrHexAl = 8'h57;

  localparam logic [GrpIdxW-1:0] PrefixLast = 3'd6;
  localparam logic [GrpIdxW-1:0] GroupLast  = 3'd7;
  localparam logic [1:0]         ByteLast   = 2'd3;
  localparam logic [RunLenW-1:0] RunEndAll  = 4'd8;
  localparam logic [31:0]        MappedTag  = 32'h0000_ffff;

  typedef struct packed {
    logic                 ok;
    logic [GrpIdxW-1:0]   at;
    logic [RunLenW-1:0]   len;
  } zrun_t;

  typedef struct packed {
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
    logic [1:0] nd;
  } dec_t;

  function automatic logic [ChrW-1:0] hex_chr(input logic [3:0] n);
    return (n < 4'd10) ? (ChrZero + {4'h0, n}) : (ChrHexAl + {4'h0, n});
  endfunction

  function automatic logic [DigW-1:0] hex_ndig(input logic [GroupW-1:0] g);
    logic [DigW-1:0] nd;
    if (g[15:12] != 4'h0) begin
      nd = 3'd4;
    end else if (g[11:8] != 4'h0) begin
      nd = 3'd3;
    end else if (g[7:4] != 4'h0) begin
      nd = 3'd2;
    end else begin
      nd = 3'd1;
    end
    return nd;
  endfunction

  // "::ffff:" lead-in of a mapped address
  function automatic logic [ChrW-1:0] prefix_chr(input logic [GrpIdxW-1:0] i);
    logic [ChrW-1:0] c;
    case (i)
      3'd2, 3'd3, 3'd4, 3'd5: c = ChrLowF;
      default:                c = ChrColon;
    endcase
    return c;
  endfunction

  // byte to decimal digits, tens by reciprocal multiply (exact below 100)
  function automatic dec_t dec_digits(input logic [7:0] b);
    dec_t          d;
    logic [7:0]    r;
    logic [14:0]   p;
    d.hun = (b >= 8'd200) ? 4'd2 : ((b >= 8'd100) ? 4'd1 : 4'd0);
    r     = b - ((b >= 8'd200) ? 8'd200 : ((b >= 8'd100) ? 8'd100 : 8'd0));
    p     = 15'(r[6:0]) * 15'd205;
    d.ten = p[14:11];
    d.one = 4'(r - 8'({d.ten, 3'b000}) - 8'({d.ten, 1'b0}));
    d.nd  = (b >= 8'd100) ? 2'd3 : ((b >= 8'd10) ? 2'd2 : 2'd1);
    return d;
  endfunction

endpackage

// ----- hdl/ipf_if.sv -----
// ----------------------------------------------------------------------------
// ipf_req_if / ipf_chr_if
// Valid/ready channels of the formatter: address requests in, characters out.
// ----------------------------------------------------------------------------
interface ipf_req_if import ipf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   req_type;
  logic [AddrW-1:0]   addr_high;
  logic [AddrW-1:0]   addr_low;
  logic [BufLenW-1:0] buf_len;

  modport source (output valid, req_type, addr_high, addr_low, buf_len, input ready);
  modport sink   (input valid, req_type, addr_high, addr_low, buf_len, output ready);
endinterface

interface ipf_chr_if import ipf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ChrW-1:0] char_code;
  logic            last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

// ----- hdl/ipf_zrun.sv -----
// ----------------------------------------------------------------------------
// ipf_zrun
// Finds the longest run of zero groups in an IPv6 address, first on a tie.
// ----------------------------------------------------------------------------
module ipf_zrun import ipf_pkg::*; (
  input  logic [2*AddrW-1:0] addr_i,
  output zrun_t              run_o
);

  logic [NumGroups-1:0] zero;
  logic [RunLenW-1:0]   len_at [NumGroups];
  logic [NumGroups-1:0] alive;
  logic [RunLenW-1:0]   top_len;
  logic [GrpIdxW-1:0]   best_at;

  always_comb begin
    for (int i = 0; i < NumGroups; i++) begin
      zero[i] = (addr_i[2*AddrW-1-GroupW*i -: GroupW] == '0);
    end
    for (int i = 0; i < NumGroups; i++) begin
      len_at[i] = '0;
      alive[i]  = 1'b1;
      for (int j = i; j < NumGroups; j++) begin
        if (alive[i] && zero[j]) begin
          len_at[i] = len_at[i] + 4'd1;
        end else begin
          alive[i] = 1'b0;
        end
      end
    end
    top_len = '0;
    best_at = '0;
    for (int i = 0; i < NumGroups; i++) begin
      if (len_at[i] > top_len) begin
        top_len = len_at[i];
        best_at = GrpIdxW'(i);
      end
    end
    run_o.ok  = (top_len >= 4'd2);
    run_o.at  = best_at;
    run_o.len = top_len;
  end

endmodule

// ----- hdl/ip_address_text_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// ip_address_text_formatter_unit
// Turns one address request into its text form, one character per transaction.
// ----------------------------------------------------------------------------
// req_i carries one address per transaction: kind, 128 address bits and the
// destination size. chr_o returns the text one ASCII character per transaction
// and closes the text with a NUL marked by last_char. IPv4 is dotted
// decimal, IPv6 is compressed lower-case hex, a mapped address shows as
// ::ffff: and dotted decimal, any other kind as a question mark. The text is
// cut to buf_len - 1 characters; buf_len of zero gives no output at all.
// A request goes from the input register into the formatter, which writes its
// characters into the output register, one per cycle while the receiver takes
// them; the next request waits in the input register meanwhile and is loaded
// in the cycle the NUL is issued. A zero-length request is loaded and leaves
// the formatter idle.
// A stalled receiver freezes the output register and the formatter; the input
// register still takes one request. Reset empties every stage, no
// transaction is pending afterwards.
// ----------------------------------------------------------------------------
module ip_address_text_formatter_unit import ipf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipf_req_if.sink    req_i,
  ipf_chr_if.source  chr_o
);

  // input register
  logic               inq_valid_q, inq_valid_d;
  logic [KindW-1:0]   inq_type_q;
  logic [AddrW-1:0]   inq_hi_q, inq_lo_q;
  logic [BufLenW-1:0] inq_len_q;

  // formatter
  state_e             state_q, state_d;
  logic [2*AddrW-1:0] addr_q, addr_d;
  logic [QuadW-1:0]   quad_q, quad_d;
  zrun_t              run_q, run_d;
  logic [GrpIdxW-1:0] idx_q, idx_d;
  logic [DigW-1:0]    dig_q, dig_d;
  logic [BufLenW-1:0] cnt_q, cnt_d;
  logic [BufLenW-1:0] lim_q, lim_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [ChrW-1:0]    out_chr_q, out_chr_d;
  logic               out_last_q, out_last_d;

  logic               accept, adv, load, mapped;
  zrun_t              run_new;
  logic [GroupW-1:0]  grp;
  logic [DigW-1:0]    nd_hex, pos;
  logic [RunLenW-1:0] run_end;
  logic               run_head;
  logic [7:0]         byte_v;
  dec_t               dd;
  logic [DigW-1:0]    ci;
  logic [3:0]         dsel;
  logic [ChrW-1:0]    chr_n;
  logic [GrpIdxW-1:0] idx_n;
  logic [DigW-1:0]    dig_n;
  logic               done, go_dec;

  ipf_zrun u_zrun (
    .addr_i ({inq_hi_q, inq_lo_q}),
    .run_o  (run_new)
  );

  assign adv    = !out_valid_q || chr_o.ready;
  assign load   = inq_valid_q && ((state_q == ST_IDLE) || ((state_q == ST_NUL) && adv));
  assign accept = req_i.valid && req_i.ready;
  assign mapped = (inq_hi_q == '0) && (inq_lo_q[AddrW-1:QuadW] == MappedTag);

  assign req_i.ready     = !inq_valid_q || load;
  assign chr_o.valid     = out_valid_q;
  assign chr_o.char_code = out_chr_q;
  assign chr_o.last_char = out_last_q;

  assign inq_valid_d = (inq_valid_q && !load) || accept;

  // character at the cursor and the following cursor
  always_comb begin
    grp      = addr_q[2*AddrW-1-GroupW*idx_q -: GroupW];
    nd_hex   = hex_ndig(grp);
    pos      = nd_hex - dig_q;
    run_end  = {1'b0, run_q.at} + run_q.len;
    run_head = run_q.ok && (idx_q == run_q.at);
    byte_v   = quad_q[QuadW-1-8*idx_q[1:0] -: 8];
    dd       = dec_digits(byte_v);
    ci       = 3'd2 - {1'b0, dd.nd} + dig_q;
    case (ci)
      3'd0:    dsel = dd.hun;
      3'd1:    dsel = dd.ten;
      default: dsel = dd.one;
    endcase
    chr_n  = ChrNul;
    idx_n  = idx_q;
    dig_n  = dig_q;
    done   = 1'b0;
    go_dec = 1'b0;
    case (state_q)
      ST_PREFIX: begin
        chr_n = prefix_chr(idx_q);
        if (idx_q == PrefixLast) begin
          go_dec = 1'b1;
        end else begin
          idx_n = idx_q + 3'd1;
        end
      end
      ST_HEX: begin
        if ((dig_q == '0) || (run_head && (dig_q == 3'd1))) begin
          chr_n = ChrColon;
        end else begin
          chr_n = hex_chr(grp[{pos[1:0], 2'b00} +: 4]);
        end
        if (run_head && (dig_q == '0)) begin
          dig_n = 3'd1;
        end else if (run_head && (dig_q == 3'd1)) begin
          if (run_end == RunEndAll) begin
            done = 1'b1;
          end else begin
            idx_n = run_end[GrpIdxW-1:0];
            dig_n = 3'd1;
          end
        end else if (dig_q < nd_hex) begin
          dig_n = dig_q + 3'd1;
        end else if (idx_q == GroupLast) begin
          done = 1'b1;
        end else begin
          idx_n = idx_q + 3'd1;
          dig_n = '0;
        end
      end
      ST_DEC: begin
        chr_n = (dig_q == '0) ? ChrDot : (ChrZero + {4'h0, dsel});
        if (dig_q < {1'b0, dd.nd}) begin
          dig_n = dig_q + 3'd1;
        end else if (idx_q[1:0] == ByteLast) begin
          done = 1'b1;
        end else begin
          idx_n = idx_q + 3'd1;
          dig_n = '0;
        end
      end
      ST_QUERY: begin
        chr_n = ChrQuery;
        done  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    quad_d      = quad_q;
    run_d       = run_q;
    idx_d       = idx_q;
    dig_d       = dig_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    out_valid_d = out_valid_q && !chr_o.ready;
    out_chr_d   = out_chr_q;
    out_last_d  = out_last_q;
    if ((state_q != ST_IDLE) && adv) begin
      out_valid_d = 1'b1;
      out_last_d  = (state_q == ST_NUL);
      out_chr_d   = (state_q == ST_NUL) ? ChrNul : chr_n;
      if (state_q == ST_NUL) begin
        state_d = ST_IDLE;
      end else begin
        cnt_d = cnt_q + 6'd1;
        idx_d = idx_n;
        dig_d = dig_n;
        if (go_dec) begin
          state_d = ST_DEC;
          idx_d   = '0;
          dig_d   = 3'd1;
        end
        if (done || (cnt_d == lim_q)) begin
          state_d = ST_NUL;
        end
      end
    end
    if (load) begin
      addr_d = {inq_hi_q, inq_lo_q};
      run_d  = run_new;
      cnt_d  = '0;
      lim_d  = inq_len_q - 6'd1;
      idx_d  = '0;
      dig_d  = 3'd1;
      quad_d = inq_hi_q[AddrW-1 -: QuadW];
      if (inq_len_q == '0) begin
        state_d = ST_IDLE;
      end else if (inq_len_q == 6'd1) begin
        state_d = ST_NUL;
      end else if (inq_type_q == KIND_V4) begin
        state_d = ST_DEC;
      end else if (inq_type_q == KIND_V6) begin
        if (mapped) begin
          state_d = ST_PREFIX;
          quad_d  = inq_lo_q[QuadW-1:0];
        end else begin
          state_d = ST_HEX;
          dig_d   = (run_new.ok && (run_new.at == '0)) ? 3'd0 : 3'd1;
        end
      end else begin
        state_d = ST_QUERY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      dig_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      inq_valid_q <= inq_valid_d;
      state_q     <= state_d;
      idx_q       <= idx_d;
      dig_q       <= dig_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inq_type_q <= req_i.req_type;
      inq_hi_q   <= req_i.addr_high;
      inq_lo_q   <= req_i.addr_low;
      inq_len_q  <= req_i.buf_len;
    end
    addr_q     <= addr_d;
    quad_q     <= quad_d;
    run_q      <= run_d;
    lim_q      <= lim_d;
    out_chr_q  <= out_chr_d;
    out_last_q <= out_last_d;
  end

endmodule

// ----- hdl/ipf_checker.sv -----
// ----------------------------------------------------------------------------
// ipf_checker
// Port-level checks of the address text formatter, bound to the top level.
// ----------------------------------------------------------------------------
module ipf_checker import ipf_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            chr_valid_i,
  input logic            chr_ready_i,
  input logic [ChrW-1:0] chr_code_i,
  input logic            chr_last_i
);

  logic [BufLenW-1:0] run_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q <= '0;
    end else if (chr_valid_i && chr_ready_i) begin
      run_cnt_q <= chr_last_i ? '0 : (run_cnt_q + 6'd1);
    end
  end

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chr_valid_i && !chr_ready_i |=> chr_valid_i && $stable(chr_code_i) && $stable(chr_last_i))
    else $error("stalled character changed");

  a_last_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chr_valid_i && chr_last_i |-> chr_code_i == ChrNul)
    else $error("closing transaction is not a NUL");

  a_body_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chr_valid_i && !chr_last_i |-> chr_code_i != ChrNul)
    else $error("NUL inside the text");

  a_text_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chr_valid_i && chr_ready_i && !chr_last_i |-> run_cnt_q < 6'd39)
    else $error("text longer than 39 characters");

endmodule

bind ip_address_text_formatter_unit ipf_checker u_ipf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .chr_valid_i (chr_o.valid),
  .chr_ready_i (chr_o.ready),
  .chr_code_i  (chr_o.char_code),
  .chr_last_i  (chr_o.last_char)
);

// ----- tb/ipf_text_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_text_checker
// Watches the request and character channels of the address text formatter,
// works out the text each accepted request should give and compares every
// accepted character, in order, with the oldest character still owed.
// ----------------------------------------------------------------------------
module ipf_text_checker import ipf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ipf_req_if          req_mon,
  ipf_chr_if          chr_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned req_count_o,
  output int unsigned chr_count_o,
  output int unsigned trunc_count_o
);

  typedef struct packed {
    logic [ChrW-1:0] code;
    logic            last;
  } owed_chr_t;

  owed_chr_t       owed_text[$];
  logic [ChrW-1:0] text_q[$];

  initial begin
    fail_count_o  = 0;
    pending_o     = 0;
    req_count_o   = 0;
    chr_count_o   = 0;
    trunc_count_o = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count_o < 30) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
    fail_count_o++;
  endtask

  function automatic void push_dec(input logic [7:0] v);
    int unsigned d;
    d = v;
    if (d >= 100) text_q.push_back(ChrZero + 8'(d / 100));
    if (d >= 10) text_q.push_back(ChrZero + 8'((d / 10) % 10));
    text_q.push_back(ChrZero + 8'(d % 10));
  endfunction

  function automatic void push_quad(input logic [QuadW-1:0] w);
    push_dec(w[31:24]);
    text_q.push_back(ChrDot);
    push_dec(w[23:16]);
    text_q.push_back(ChrDot);
    push_dec(w[15:8]);
    text_q.push_back(ChrDot);
    push_dec(w[7:0]);
  endfunction

  function automatic void push_group(input logic [GroupW-1:0] g);
    int         sh;
    logic [3:0] nib;
    sh = 12;
    while (sh > 0 && g[sh +: 4] == 4'h0) sh -= 4;
    for (; sh >= 0; sh -= 4) begin
      nib = g[sh +: 4];
      text_q.push_back((nib < 4'd10) ? ChrZero + 8'(nib) : ChrHexAl + 8'(nib));
    end
  endfunction

  function automatic void push_v6(input logic [AddrW-1:0] hi, input logic [AddrW-1:0] lo);
    logic [GroupW-1:0] grp [NumGroups];
    int                i;
    int                j;
    int                run_at;
    int                run_len;
    if (hi == '0 && lo[63:32] == MappedTag) begin
      text_q.push_back(ChrColon);
      text_q.push_back(ChrColon);
      repeat (4) text_q.push_back(ChrLowF);
      text_q.push_back(ChrColon);
      push_quad(lo[31:0]);
      return;
    end
    for (i = 0; i < 4; i++) begin
      grp[i]     = hi[63 - 16 * i -: 16];
      grp[i + 4] = lo[63 - 16 * i -: 16];
    end
    // longest zero run, first one wins a tie
    run_at  = -1;
    run_len = 0;
    i       = 0;
    while (i < NumGroups) begin
      if (grp[i] != '0) begin
        i++;
      end else begin
        j = i;
        while (j < NumGroups && grp[j] == '0) j++;
        if (j - i > run_len) begin
          run_at  = i;
          run_len = j - i;
        end
        i = j;
      end
    end
    if (run_len < 2) run_at = -1;
    i = 0;
    while (i < NumGroups) begin
      if (i == run_at) begin
        text_q.push_back(ChrColon);
        text_q.push_back(ChrColon);
        i += run_len;
      end else begin
        if (i > 0 && !(run_at >= 0 && i == run_at + run_len)) text_q.push_back(ChrColon);
        push_group(grp[i]);
        i++;
      end
    end
  endfunction

  function automatic void predict_text(input logic [KindW-1:0] kind,
                                       input logic [AddrW-1:0] hi,
                                       input logic [AddrW-1:0] lo,
                                       input logic [BufLenW-1:0] blen);
    int n;
    if (blen == '0) return;
    text_q.delete();
    case (kind)
      KIND_V4: push_quad(hi[63:32]);
      KIND_V6: push_v6(hi, lo);
      default: text_q.push_back(ChrQuery);
    endcase
    n = text_q.size();
    if (n > int'(blen) - 1) begin
      n = int'(blen) - 1;
      trunc_count_o++;
    end
    for (int k = 0; k < n; k++) owed_text.push_back('{code: text_q[k], last: 1'b0});
    owed_text.push_back('{code: ChrNul, last: 1'b1});
  endfunction

  always @(posedge clk_i) begin
    owed_chr_t want;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) begin
        predict_text(req_mon.req_type, req_mon.addr_high, req_mon.addr_low, req_mon.buf_len);
        req_count_o++;
      end
      if (chr_mon.valid && chr_mon.ready) begin
        chr_count_o++;
        if (owed_text.size() == 0) begin
          report_mismatch($sformatf("character %02h last %0b with nothing outstanding",
                                    chr_mon.char_code, chr_mon.last_char));
        end else begin
          want = owed_text.pop_front();
          if (chr_mon.char_code !== want.code || chr_mon.last_char !== want.last) begin
            report_mismatch($sformatf("character %0d: got %02h last %0b, want %02h last %0b",
                                      chr_count_o, chr_mon.char_code, chr_mon.last_char,
                                      want.code, want.last));
          end
        end
      end
      pending_o = owed_text.size();
    end
  end

endmodule

// ----- tb/ip_address_text_formatter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_formatter_unit_tb
// Drives address requests into the formatter: a directed set covering IPv4,
// IPv6 compression rules, mapped addresses, unknown kinds and truncation,
// then random requests with idle bursts on both sides and one long receiver
// hold-off. The checker beside the block predicts and compares the text.
// ----------------------------------------------------------------------------
module ip_address_text_formatter_unit_tb;
  import ipf_pkg::*;

  localparam logic [KindW-1:0] KindReserved = 2'd3;
  localparam int unsigned      LongHold     = 300;
  localparam int unsigned      IdleLimit    = 3000;
  localparam int unsigned      TailCycles   = 60;

  logic        clk_i;
  logic        rst_ni;
  bit          src_gaps;
  bit          sink_gaps;
  int unsigned hold_reqs;
  int unsigned holds_done;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned req_count;
  int unsigned chr_count;
  int unsigned trunc_count;

  ipf_req_if req_if ();
  ipf_chr_if chr_if ();

  ip_address_text_formatter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .chr_o  (chr_if)
  );

  ipf_text_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_if),
    .chr_mon       (chr_if),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .req_count_o   (req_count),
    .chr_count_o   (chr_count),
    .trunc_count_o (trunc_count)
  );

  initial clk_i = 1'b0;
  always #4ns clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [GroupW-1:0] rand_group();
    logic [GroupW-1:0] g;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: g = '0;
      4:          g = 16'($urandom_range(1, 16'h000f));
      5:          g = 16'($urandom_range(1, 16'h00ff));
      6:          g = 16'($urandom_range(1, 16'h0fff));
      default:    g = 16'($urandom);
    endcase
    return g;
  endfunction

  task automatic send_req(input logic [KindW-1:0] kind, input logic [AddrW-1:0] hi,
                          input logic [AddrW-1:0] lo, input logic [BufLenW-1:0] blen);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.addr_high <= hi;
    req_if.addr_low  <= lo;
    req_if.buf_len   <= blen;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [KindW-1:0]   kind;
    logic [AddrW-1:0]   hi;
    logic [AddrW-1:0]   lo;
    logic [BufLenW-1:0] blen;
    hi = rand64();
    lo = rand64();
    case ($urandom_range(0, 9))
      0, 1, 2: kind = KIND_V4;
      8:       kind = KIND_UNK;
      9:       kind = KindReserved;
      default: kind = KIND_V6;
    endcase
    if (kind == KIND_V6) begin
      case ($urandom_range(0, 9))
        0:       begin hi = '0; lo[63:32] = MappedTag; end
        1:       ;
        default: begin
          hi = {rand_group(), rand_group(), rand_group(), rand_group()};
          lo = {rand_group(), rand_group(), rand_group(), rand_group()};
        end
      endcase
    end
    case ($urandom_range(0, 5))
      0, 1:    blen = 6'($urandom_range(0, 63));
      2:       blen = 6'($urandom_range(0, 3));
      default: blen = 6'($urandom_range(40, 63));
    endcase
    send_req(kind, hi, lo, blen);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // receiver side
  initial begin
    chr_if.ready <= 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        chr_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        chr_if.ready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        chr_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        chr_if.ready <= 1'b1;
      end else begin
        chr_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (chr_if.valid && chr_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("[ip_address_text_formatter_unit] ERROR");
    $finish;
  end

  initial begin
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= KIND_V4;
    req_if.addr_high <= '0;
    req_if.addr_low  <= '0;
    req_if.buf_len   <= '0;
    hold_reqs        <= 0;
    sink_gaps        <= 1'b1;
    src_gaps         = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dotted decimal, unused low bits set
    send_req(KIND_V4, {32'h0000_0000, $urandom}, rand64(), 6'd63);
    send_req(KIND_V4, {32'hffff_ffff, 32'h0}, '1, 6'd40);
    send_req(KIND_V4, {32'h0a64_09c8, $urandom}, '0, 6'd16);
    // compression rules
    send_req(KIND_V6, '0, '0, 6'd63);
    send_req(KIND_V6, '1, '1, 6'd40);
    send_req(KIND_V6, '0, 64'h1, 6'd40);
    send_req(KIND_V6, 64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0001, 6'd63);
    send_req(KIND_V6, 64'h2001_0db8_0000_0001, 64'h0001_0001_0001_0001, 6'd63);
    send_req(KIND_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004, 6'd63);
    send_req(KIND_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003, 6'd63);
    send_req(KIND_V6, 64'h0001_0002_0000_0000, '0, 6'd63);
    send_req(KIND_V6, 64'h1000_0100_0010_0001, 64'habcd_0000_ef01_0000, 6'd63);
    // mapped and nearly mapped
    send_req(KIND_V6, '0, 64'h0000_ffff_c0a8_0101, 6'd63);
    send_req(KIND_V6, '0, 64'h0000_fffe_c0a8_0101, 6'd63);
    send_req(KIND_V6, 64'h1, 64'h0000_ffff_0102_0304, 6'd63);
    // unknown kinds
    send_req(KIND_UNK, rand64(), rand64(), 6'd63);
    send_req(KindReserved, rand64(), rand64(), 6'd10);
    // buffer sizes
    send_req(KIND_V6, '1, '1, 6'd0);
    send_req(KIND_V4, rand64(), rand64(), 6'd1);
    send_req(KIND_V6, '1, '1, 6'd2);
    send_req(KIND_V6, '1, '1, 6'd39);
    send_req(KIND_V6, '0, 64'h0000_ffff_ffff_ffff, 6'd20);
    send_req(KIND_UNK, rand64(), rand64(), 6'd0);
    send_req(KIND_V6, '0, '0, 6'd2);

    repeat (180) send_random();

    // receiver stops for a long stretch while requests keep coming
    hold_reqs <= hold_reqs + 1;
    src_gaps = 1'b0;
    repeat (20) send_random();
    src_gaps = 1'b1;

    req_if.valid <= 1'b0;
    wait_drained();

    repeat (150) send_random();

    src_gaps = 1'b0;
    sink_gaps <= 1'b0;
    repeat (100) send_random();
    req_if.valid <= 1'b0;

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d requests of every kind, buffer sizes 0 to 63 (%0d truncated)",
             req_count, trunc_count);
    $display("checked %0d characters with idle bursts and one long receiver hold-off",
             chr_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ip_address_text_formatter_unit] OK");
    end else begin
      $display("[ip_address_text_formatter_unit] ERROR");
    end
    $finish;
  end

endmodule
